>>> hw/rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg: shared definitions for the lyric line timestamp parser
// Byte codes, position limits and the command and status records that
// pass between the parser controller and its datapath.
// ----------------------------------------------------------------------------
package lrc_pkg;

	localparam int LINE_LIMIT  = 1024;
	localparam int POS_W       = 10;
	localparam int POS_MAX_INT = (LINE_LIMIT - 1 > 1023) ? 1023 : LINE_LIMIT - 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_MAX_INT);

	localparam int TIME_W = 32;
	localparam int FRAC_W = 10;
	localparam int FCNT_W = 2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;
	localparam logic [7:0] CH_BOM0   = 8'hEF;
	localparam logic [7:0] CH_BOM1   = 8'hBB;
	localparam logic [7:0] CH_BOM2   = 8'hBF;

	localparam logic [FCNT_W-1:0] FRAC_DIGITS = FCNT_W'(3);

	// Datapath operations requested by the controller for the current word.
	typedef struct packed {
		logic step_pos;
		logic min_acc;
		logic sec_acc;
		logic frac_acc;
		logic close_tag;
		logic mark_pos;
		logic mark_inc;
		logic load_out;
		logic out_ok;
		logic clear;
	} lrc_cmd_t;

	// Classification of the incoming byte and datapath condition flags.
	typedef struct packed {
		logic is_nul;
		logic is_space;
		logic is_quote;
		logic is_dot;
		logic is_digit;
		logic is_colon;
		logic is_open;
		logic is_close;
		logic is_bom0;
		logic is_bom1;
		logic is_bom2;
		logic frac_full;
		logic out_full;
	} lrc_stat_t;

endpackage

>>> hw/rtl/lrc_ctrl.sv
// ----------------------------------------------------------------------------
// lrc_ctrl: parser controller
// Tracks the parse phase of the line and issues datapath commands for each
// accepted word; holds off the input in the cycle after the leading tag closes.
// ----------------------------------------------------------------------------
module lrc_ctrl
	import lrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      end_of_line,
	input  logic      out_ready,
	output logic      in_ready,
	input  lrc_stat_t st,
	output lrc_cmd_t  cmd
);

	localparam logic [4:0] PH_START        = 5'd0;
	localparam logic [4:0] PH_BOM1         = 5'd1;
	localparam logic [4:0] PH_BOM2         = 5'd2;
	localparam logic [4:0] PH_AFTER_BOM    = 5'd3;
	localparam logic [4:0] PH_NEED_BRACKET = 5'd4;
	localparam logic [4:0] PH_MIN          = 5'd5;
	localparam logic [4:0] PH_SEC          = 5'd6;
	localparam logic [4:0] PH_FRAC         = 5'd7;
	localparam logic [4:0] PH_TAGS         = 5'd8;
	localparam logic [4:0] PH_XMIN_FIRST   = 5'd9;
	localparam logic [4:0] PH_XMIN         = 5'd10;
	localparam logic [4:0] PH_XSEC_FIRST   = 5'd11;
	localparam logic [4:0] PH_XSEC         = 5'd12;
	localparam logic [4:0] PH_XFRAC        = 5'd13;
	localparam logic [4:0] PH_SPACES       = 5'd14;
	localparam logic [4:0] PH_QUOTE_END    = 5'd15;
	localparam logic [4:0] PH_DONE         = 5'd16;
	localparam logic [4:0] PH_FAIL         = 5'd17;

	logic [4:0] ph_q, ph_d;
	logic       hv_q, hv_d;
	logic       busy_q;
	logic       acc;

	always_comb begin
		cmd      = '0;
		ph_d     = ph_q;
		hv_d     = hv_q;
		in_ready = !busy_q && (!end_of_line || !st.out_full || out_ready);
		acc      = in_valid && in_ready;
		if (acc) begin
			if (end_of_line || st.is_nul) begin
				// A terminator or a zero byte closes the line.
				case (ph_q)
					PH_TAGS, PH_SPACES: begin
						cmd.mark_pos = 1'b1;
						ph_d = PH_DONE;
					end
					PH_XMIN_FIRST, PH_XMIN, PH_XSEC_FIRST, PH_XSEC, PH_XFRAC: begin
						ph_d = PH_DONE;
					end
					PH_QUOTE_END: begin
						cmd.mark_inc = 1'b1;
						ph_d = PH_DONE;
					end
					PH_DONE, PH_FAIL: begin
						ph_d = ph_q;
					end
					default: begin
						hv_d = 1'b0;
						ph_d = PH_FAIL;
					end
				endcase
			end else begin
				case (ph_q)
					PH_START, PH_AFTER_BOM: begin
						if (st.is_bom0 && ph_q == PH_START) ph_d = PH_BOM1;
						else if (st.is_quote) ph_d = PH_NEED_BRACKET;
						else if (st.is_open) ph_d = PH_MIN;
						else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_BOM1: begin
						if (st.is_bom1) ph_d = PH_BOM2;
						else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_BOM2: begin
						if (st.is_bom2) ph_d = PH_AFTER_BOM;
						else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_NEED_BRACKET: begin
						if (st.is_open) ph_d = PH_MIN;
						else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_MIN: begin
						if (st.is_digit) cmd.min_acc = 1'b1;
						else if (st.is_colon) ph_d = PH_SEC;
						else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_SEC: begin
						if (st.is_digit) cmd.sec_acc = 1'b1;
						else if (st.is_dot) ph_d = PH_FRAC;
						else if (st.is_close) begin
							cmd.close_tag = 1'b1;
							hv_d = 1'b1;
							ph_d = PH_TAGS;
						end else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_FRAC: begin
						if (st.is_digit && !st.frac_full) cmd.frac_acc = 1'b1;
						else if (st.is_close) begin
							cmd.close_tag = 1'b1;
							hv_d = 1'b1;
							ph_d = PH_TAGS;
						end else begin hv_d = 1'b0; ph_d = PH_FAIL; end
					end
					PH_TAGS: begin
						if (st.is_open) begin
							cmd.mark_pos = 1'b1;
							ph_d = PH_XMIN_FIRST;
						end else if (st.is_space) ph_d = PH_SPACES;
						else if (st.is_quote) begin
							cmd.mark_pos = 1'b1;
							ph_d = PH_QUOTE_END;
						end else begin
							cmd.mark_pos = 1'b1;
							ph_d = PH_DONE;
						end
					end
					PH_XMIN_FIRST: begin
						ph_d = st.is_digit ? PH_XMIN : PH_DONE;
					end
					PH_XMIN: begin
						if (st.is_colon) ph_d = PH_XSEC_FIRST;
						else if (!st.is_digit) ph_d = PH_DONE;
					end
					PH_XSEC_FIRST: begin
						ph_d = st.is_digit ? PH_XSEC : PH_DONE;
					end
					PH_XSEC: begin
						if (st.is_dot) ph_d = PH_XFRAC;
						else if (st.is_close) ph_d = PH_TAGS;
						else if (!st.is_digit) ph_d = PH_DONE;
					end
					PH_XFRAC: begin
						if (st.is_close) ph_d = PH_TAGS;
						else if (!st.is_digit) ph_d = PH_DONE;
					end
					PH_SPACES: begin
						if (st.is_quote) begin
							cmd.mark_pos = 1'b1;
							ph_d = PH_QUOTE_END;
						end else if (!st.is_space) begin
							cmd.mark_pos = 1'b1;
							ph_d = PH_DONE;
						end
					end
					PH_QUOTE_END: begin
						ph_d = PH_DONE;
					end
					PH_DONE, PH_FAIL: begin
						ph_d = ph_q;
					end
					default: begin
						hv_d = 1'b0;
						ph_d = PH_FAIL;
					end
				endcase
			end
			if (end_of_line) begin
				cmd.load_out = 1'b1;
				cmd.out_ok   = hv_d && (ph_d == PH_DONE);
				cmd.clear    = 1'b1;
				ph_d = PH_START;
				hv_d = 1'b0;
			end else begin
				cmd.step_pos = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_START;
			hv_q   <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			hv_q   <= hv_d;
			// The input is held off while the tag time is scaled to milliseconds after the bracket.
			busy_q <= cmd.close_tag;
		end
	end

endmodule

>>> hw/rtl/lrc_dp.sv
// ----------------------------------------------------------------------------
// lrc_dp: parser datapath
// Byte classification, digit accumulators, two-step tag time calculation,
// position and text mark counters, and the result register.
// ----------------------------------------------------------------------------
module lrc_dp
	import lrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_byte,
	input  logic              out_ready,
	input  lrc_cmd_t          cmd,
	output lrc_stat_t         st,
	output logic              out_valid,
	output logic              parsed_ok,
	output logic [TIME_W-1:0] time_in_ms,
	output logic [POS_W-1:0]  text_start
);

	logic [TIME_W-1:0] min_q, sec_q, held_q;
	logic [FRAC_W-1:0] frac_q;
	logic [FCNT_W-1:0] fcnt_q;
	logic [POS_W-1:0]  pos_q, mark_q, mark_d;
	logic [TIME_W-1:0] tsec_s1;
	logic [FRAC_W-1:0] fpad_s1, fpad;
	logic              close_s1;
	logic              out_valid_q;
	logic [TIME_W-1:0] digit;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		sat_inc = (v >= POS_MAX) ? POS_MAX : v + POS_W'(1);
	endfunction

	assign digit = {{(TIME_W-4){1'b0}}, char_byte[3:0]};

	always_comb begin
		st.is_nul    = (char_byte == CH_NUL);
		st.is_space  = (char_byte == CH_SPACE);
		st.is_quote  = (char_byte == CH_QUOTE);
		st.is_dot    = (char_byte == CH_DOT);
		st.is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
		st.is_colon  = (char_byte == CH_COLON);
		st.is_open   = (char_byte == CH_OPEN);
		st.is_close  = (char_byte == CH_CLOSE);
		st.is_bom0   = (char_byte == CH_BOM0);
		st.is_bom1   = (char_byte == CH_BOM1);
		st.is_bom2   = (char_byte == CH_BOM2);
		st.frac_full = (fcnt_q == FRAC_DIGITS);
		st.out_full  = out_valid_q;
	end

	// Pad the fraction to milliseconds according to how many digits came in.
	always_comb begin
		case (fcnt_q)
			2'd1:    fpad = FRAC_W'(frac_q * FRAC_W'(100));
			2'd2:    fpad = FRAC_W'(frac_q * FRAC_W'(10));
			2'd3:    fpad = frac_q;
			default: fpad = '0;
		endcase
	end

	always_comb begin
		mark_d = mark_q;
		if (cmd.mark_pos) mark_d = pos_q;
		else if (cmd.mark_inc) mark_d = sat_inc(mark_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			sec_q       <= '0;
			frac_q      <= '0;
			fcnt_q      <= '0;
			held_q      <= '0;
			pos_q       <= '0;
			mark_q      <= '0;
			close_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			close_s1 <= cmd.close_tag;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.clear) begin
				min_q  <= '0;
				sec_q  <= '0;
				frac_q <= '0;
				fcnt_q <= '0;
				held_q <= '0;
				pos_q  <= '0;
				mark_q <= '0;
			end else begin
				if (cmd.min_acc) min_q <= min_q * TIME_W'(10) + digit;
				if (cmd.sec_acc) sec_q <= sec_q * TIME_W'(10) + digit;
				if (cmd.frac_acc) begin
					frac_q <= frac_q * FRAC_W'(10) + FRAC_W'(char_byte[3:0]);
					fcnt_q <= fcnt_q + FCNT_W'(1);
				end
				if (close_s1) held_q <= tsec_s1 * TIME_W'(1000) + TIME_W'(fpad_s1);
				if (cmd.step_pos) pos_q <= sat_inc(pos_q);
				mark_q <= mark_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close_tag) begin
			tsec_s1 <= min_q * TIME_W'(60) + sec_q;
			fpad_s1 <= fpad;
		end
		if (cmd.load_out) begin
			parsed_ok  <= cmd.out_ok;
			time_in_ms <= cmd.out_ok ? held_q : '0;
			text_start <= cmd.out_ok ? mark_d : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/lrc_timestamp_line_parser.sv
// ----------------------------------------------------------------------------
// lrc_timestamp_line_parser: lyric line timestamp parser
// Parses the leading [mm:ss.fff] tag of one lyric line and reports the tag
// time and the offset of the lyric text when the line is terminated.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------------
//  input    in_valid / in_ready  char_byte[7:0], end_of_line
//  output   out_valid/out_ready  parsed_ok, time_in_ms[31:0], text_start[9:0]
//
// One byte word is taken per cycle, except in the cycle after the closing
// bracket of the leading tag: the input is then held off while the
// minutes-and-seconds product is scaled to milliseconds by the datapath's two-step multiply.
// The terminator word gives its result in the cycle after; it waits only while a
// previous result is still held and not being taken, byte words do not.
// Reset clears the parse state, the accumulators and the output valid flag.
module lrc_timestamp_line_parser
	import lrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_byte,
	input  logic              end_of_line,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              parsed_ok,
	output logic [TIME_W-1:0] time_in_ms,
	output logic [POS_W-1:0]  text_start
);

	lrc_cmd_t  cmd;
	lrc_stat_t st;

	lrc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.end_of_line (end_of_line),
		.out_ready   (out_ready),
		.in_ready    (in_ready),
		.st          (st),
		.cmd         (cmd)
	);

	lrc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_byte  (char_byte),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.parsed_ok  (parsed_ok),
		.time_in_ms (time_in_ms),
		.text_start (text_start)
	);

endmodule

>>> hw/rtl/lrc_checker.sv
// ----------------------------------------------------------------------------
// lrc_checker: port-level checks for the lyric line timestamp parser
// Watches the top-level ports and flags results that could not come from a
// correctly terminated line.
// ----------------------------------------------------------------------------
module lrc_checker
	import lrc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              end_of_line,
	input logic              out_valid,
	input logic              out_ready,
	input logic              parsed_ok,
	input logic [TIME_W-1:0] time_in_ms,
	input logic [POS_W-1:0]  text_start
);

	// A held result keeps its word until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(time_in_ms) && $stable(text_start))
		else $error("result word changed while stalled");

	// A failed line reports zero time and zero offset.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parsed_ok |-> time_in_ms == '0 && text_start == '0)
		else $error("failed line carries non-zero fields");

	// Results appear only after a terminator word has been taken.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && end_of_line))
		else $error("result without terminator");

	// A terminator is never taken while an untaken result would be overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_line |-> !out_valid || out_ready)
		else $error("terminator accepted over a pending result");

	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> text_start <= POS_MAX)
		else $error("text offset beyond line limit");

endmodule

bind lrc_timestamp_line_parser lrc_checker u_lrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.end_of_line (end_of_line),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.parsed_ok   (parsed_ok),
	.time_in_ms  (time_in_ms),
	.text_start  (text_start)
);
